[hw/rtl/uvf_pkg.sv]
// Shared types and status codes for the unique-value FIFO.
package uvf_pkg;

	localparam int unsigned DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic                     op_t;
	typedef logic [1:0]               status_t;

	localparam op_t OP_ENQ = 1'b0;
	localparam op_t OP_DEQ = 1'b1;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_DUP   = 2'd2;
	localparam status_t ST_EMPTY = 2'd3;

endpackage

[hw/rtl/uvf_req_if.sv]
// Request channel: operation and value, valid/ready handshake.
interface uvf_req_if;
	import uvf_pkg::*;

	logic  valid;
	logic  ready;
	op_t   op;
	data_t value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

[hw/rtl/uvf_rsp_if.sv]
// Response channel: status and value, valid/ready handshake.
interface uvf_rsp_if;
	import uvf_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	data_t   value_out;

	modport source (output valid, output status, output value_out, input ready);
	modport sink   (input valid, input status, input value_out, output ready);
endinterface

[hw/rtl/unique_value_fifo_core.sv]
// FIFO of signed 32-bit values that rejects duplicates; one compare per stored entry.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+---------------------------------
//  req     | in  | valid/ready | op (0 enqueue, 1 dequeue), value
//  rsp     | out | valid/ready | status, value_out
//
// Enqueue: the single RAM read port and one comparator walk every stored entry,
// one per cycle, stopping early on a match. Full enqueue, enqueue into an empty queue
// and empty dequeue answer the cycle after acceptance; dequeue runs S_DEQ_RD, S_DEQ_DAT.
// One transaction is in flight at a time; req.ready is low while it runs and
// while an earlier response still waits on rsp.ready.
// Reset clears count, head and tail; RAM contents are not cleared.
module unique_value_fifo_core #(
	parameter int unsigned DEPTH = 512
) (
	input logic     clk,
	input logic     arst_n,
	uvf_req_if.sink   req,
	uvf_rsp_if.source rsp
);
	import uvf_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_SCAN    = 2'd1;
	localparam logic [1:0] S_DEQ_RD  = 2'd2;
	localparam logic [1:0] S_DEQ_DAT = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] scan_ptr_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] issued_q;
	logic          cmp_vld_s1;
	data_t         val_q;

	logic          out_vld_q;
	status_t       out_status_q;
	data_t         out_value_q;

	logic          accept;
	logic          issue;
	logic          match;
	logic          scan_last;
	logic          ram_we;
	data_t         ram_wdata;
	logic [DATA_W-1:0] rd_data;
	logic          done;
	status_t       done_status;
	data_t         done_value;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		r = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
		return r;
	endfunction

	assign req.ready = (state_q == S_IDLE) && (!out_vld_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// one RAM read per cycle; the compare uses the registered read data
	assign issue     = ((state_q == S_SCAN) && (issued_q != count_q)) || (state_q == S_DEQ_RD);
	assign match     = cmp_vld_s1 && (data_t'(rd_data) == val_q);
	assign scan_last = cmp_vld_s1 && (issued_q == count_q);

	assign ram_we    = (accept && (req.op == OP_ENQ) && (count_q == '0))
	                || ((state_q == S_SCAN) && scan_last && !match);
	assign ram_wdata = (state_q == S_IDLE) ? req.value : val_q;

	uvf_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(scan_ptr_q),
		.rdata(rd_data)
	);

	always_comb begin
		done        = 1'b0;
		done_status = ST_OK;
		done_value  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.op == OP_DEQ) begin
						if (count_q == '0) begin
							done        = 1'b1;
							done_status = ST_EMPTY;
						end
					end else if (count_q == CW'(DEPTH)) begin
						done        = 1'b1;
						done_status = ST_FULL;
					end else if (count_q == '0) begin
						done        = 1'b1;
						done_value  = req.value;
					end
				end
			end
			S_SCAN: begin
				if (match) begin
					done        = 1'b1;
					done_status = ST_DUP;
					done_value  = val_q;
				end else if (scan_last) begin
					done        = 1'b1;
					done_value  = val_q;
				end
			end
			S_DEQ_RD: begin
			end
			S_DEQ_DAT: begin
				done       = 1'b1;
				done_value = data_t'(rd_data);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			scan_ptr_q <= '0;
			count_q    <= '0;
			issued_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			out_vld_q <= done || (out_vld_q && !rsp.ready);
			if (ram_we) begin
				tail_q  <= ptr_inc(tail_q);
				count_q <= count_q + CW'(1);
			end
			cmp_vld_s1 <= issue && (state_q == S_SCAN) && !match && !scan_last;
			if (issue) begin
				scan_ptr_q <= ptr_inc(scan_ptr_q);
				issued_q   <= issued_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && !done) begin
						scan_ptr_q <= head_q;
						issued_q   <= '0;
						state_q    <= (req.op == OP_DEQ) ? S_DEQ_RD : S_SCAN;
					end
				end
				S_SCAN: begin
					if (done) begin
						state_q <= S_IDLE;
					end
				end
				S_DEQ_RD: begin
					state_q <= S_DEQ_DAT;
				end
				S_DEQ_DAT: begin
					head_q  <= ptr_inc(head_q);
					count_q <= count_q - CW'(1);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= req.value;
		end
		if (done) begin
			out_status_q <= done_status;
			out_value_q  <= done_value;
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.status    = out_status_q;
	assign rsp.value_out = out_value_q;

	// a pending response never sits alongside a running transaction
	a_no_resp_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !out_vld_q)
		else $error("response pending while a transaction is in progress");

	a_empty_deq_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.op == OP_DEQ) && (count_q == '0))
		|=> (rsp.valid && (rsp.status == ST_EMPTY) && (count_q == '0)))
		else $error("dequeue from empty queue did not answer empty");

	a_write_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (count_q < CW'(DEPTH)))
		else $error("write into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ((issued_q <= count_q) && (count_q != '0)))
		else $error("scan ran past the stored entries");

endmodule

[hw/rtl/uvf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module uvf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 512
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
